// ===== rtl/core/lhdf_pkg.sv =====
// ----------------------------------------------------------------------------
// lhdf_pkg
// Shared types and constants for the line hash duplicate filter.
// ----------------------------------------------------------------------------
package lhdf_pkg;

  // Field widths
  localparam int ByteW   = 8;
  localparam int HashW   = 23;
  localparam int WordW   = 32;
  localparam int BitIdxW = 5;                 // bit select inside one bitmap word
  localparam int IdxW    = HashW - BitIdxW;   // bitmap word index taken from a hash
  localparam int ProdW   = HashW + ByteW;     // hash times multiplier

  // Hash arithmetic
  localparam logic [HashW-1:0] HashModulus = 23'd8388593;
  localparam int               HashMult    = 199;
  // 2^HashW folded back modulo the hash modulus
  localparam int               FoldMult    = (1 << HashW) - 8388593;

  // Bitmap size default
  localparam int BitmapWordsDef = (1024 * 1024 * 8) / WordW;

  // Result queue
  localparam int OutFifoDepth = 4;
  localparam int OutCntW      = $clog2(OutFifoDepth + 1);

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             end_of_line;
  } in_word_t;

  typedef struct packed {
    logic [HashW-1:0] line_hash;
    logic             first_seen;
  } out_word_t;

  // Lookup stage result toward the result queue
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } seen_result_t;

endpackage

// ===== rtl/core/lhdf_ram.sv =====
// ----------------------------------------------------------------------------
// lhdf_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lhdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lhdf_hash.sv =====
// ----------------------------------------------------------------------------
// lhdf_hash
// Running polynomial line hash, one byte per cycle.
// ----------------------------------------------------------------------------
module lhdf_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         absorb_i,
  input  logic                         clear_i,
  input  logic [lhdf_pkg::ByteW-1:0]   byte_i,
  output logic [lhdf_pkg::HashW-1:0]   hash_o
);

  localparam int FoldW = lhdf_pkg::HashW + 1;

  logic [lhdf_pkg::HashW-1:0] hash_q, hash_d;
  logic [lhdf_pkg::ProdW-1:0] prod;
  logic [lhdf_pkg::WordW-1:0] sum;
  logic [FoldW-1:0]           fold;
  logic [FoldW-1:0]           diff;
  logic [lhdf_pkg::HashW-1:0] hash_next;

  // h*199 plus the sign-extended byte, wrapping at 32 bits
  assign prod = lhdf_pkg::ProdW'(hash_q) * lhdf_pkg::ProdW'(lhdf_pkg::HashMult);
  assign sum  = lhdf_pkg::WordW'(prod)
              + {{(lhdf_pkg::WordW - lhdf_pkg::ByteW){byte_i[lhdf_pkg::ByteW-1]}}, byte_i};

  // Fold the top bits back (2^23 = 15 mod m); result stays below 2m
  assign fold = {1'b0, sum[lhdf_pkg::HashW-1:0]}
              + FoldW'(sum[lhdf_pkg::WordW-1:lhdf_pkg::HashW]) * FoldW'(lhdf_pkg::FoldMult);
  assign diff = fold - {1'b0, lhdf_pkg::HashModulus};

  always_comb begin
    if (fold >= {1'b0, lhdf_pkg::HashModulus}) begin
      hash_next = diff[lhdf_pkg::HashW-1:0];
    end else begin
      hash_next = fold[lhdf_pkg::HashW-1:0];
    end
  end

  // Line end restarts from zero
  always_comb begin
    hash_d = hash_q;
    if (clear_i) begin
      hash_d = '0;
    end else if (absorb_i) begin
      hash_d = hash_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;

`ifndef NO_ASSERTIONS
  // Running hash stays a residue of the modulus
  a_hash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_q < lhdf_pkg::HashModulus)
    else $error("running hash out of range");
`endif

endmodule

// ===== rtl/core/lhdf_seen.sv =====
// ----------------------------------------------------------------------------
// lhdf_seen
// Seen bitmap: read-modify-write of one bit per line hash, with forwarding
// of the last written word and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module lhdf_seen #(
  parameter int BITMAP_WORDS = lhdf_pkg::BitmapWordsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       lookup_en_i,
  input  logic [lhdf_pkg::HashW-1:0] lookup_hash_i,
  output logic                       busy_o,
  output lhdf_pkg::seen_result_t     result_o
);

  localparam int AddrW = $clog2(BITMAP_WORDS);

  // Clear sweep
  logic             busy_q, busy_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  // Lookup stage (memory data arrives here)
  logic                       s1_valid_q;
  logic                       s1_inrange_q;
  logic [lhdf_pkg::HashW-1:0] s1_hash_q;

  // Last written word
  logic                       fwd_valid_q, fwd_valid_d;
  logic [AddrW-1:0]           fwd_addr_q;
  logic [lhdf_pkg::WordW-1:0] fwd_data_q;

  logic [lhdf_pkg::IdxW-1:0]  lookup_idx;
  logic                       lookup_inrange;
  logic [AddrW-1:0]           s1_addr;
  logic [lhdf_pkg::WordW-1:0] rdata;
  logic [lhdf_pkg::WordW-1:0] cur_word;
  logic [lhdf_pkg::WordW-1:0] bit_mask;
  logic [lhdf_pkg::WordW-1:0] new_word;
  logic                       seen;

  logic                       ram_we;
  logic [AddrW-1:0]           ram_waddr;
  logic [lhdf_pkg::WordW-1:0] ram_wdata;

  assign lookup_idx     = lookup_hash_i[lhdf_pkg::HashW-1:lhdf_pkg::BitIdxW];
  assign lookup_inrange = 32'(lookup_idx) < 32'(BITMAP_WORDS);
  assign s1_addr        = AddrW'(s1_hash_q[lhdf_pkg::HashW-1:lhdf_pkg::BitIdxW]);

  lhdf_ram #(
    .WIDTH(lhdf_pkg::WordW),
    .DEPTH(BITMAP_WORDS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (lookup_en_i),
    .raddr_i(AddrW'(lookup_idx)),
    .rdata_o(rdata)
  );

  // Word as it is now: the previous cycle's write may have missed the read
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      cur_word = fwd_data_q;
    end else begin
      cur_word = rdata;
    end
  end

  assign bit_mask = lhdf_pkg::WordW'(1) << s1_hash_q[lhdf_pkg::BitIdxW-1:0];
  assign seen     = s1_inrange_q && ((cur_word & bit_mask) != '0);
  assign new_word = cur_word | bit_mask;

  // Write port: zero sweep, else bit set on first sight
  always_comb begin
    if (busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_q && s1_inrange_q && !seen;
      ram_waddr = s1_addr;
      ram_wdata = new_word;
    end
  end

  // Sweep control
  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AddrW'(BITMAP_WORDS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  assign fwd_valid_d = s1_valid_q && s1_inrange_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= lookup_en_i;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (lookup_en_i) begin
      s1_hash_q    <= lookup_hash_i;
      s1_inrange_q <= lookup_inrange;
    end
    if (fwd_valid_d) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= new_word;
    end
  end

  assign busy_o                    = busy_q;
  assign result_o.valid            = s1_valid_q;
  assign result_o.word.line_hash   = s1_hash_q;
  assign result_o.word.first_seen  = !seen;

`ifndef NO_ASSERTIONS
  // No lookup while the bitmap is being cleared
  a_no_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_en_i |-> !busy_q)
    else $error("lookup during clear sweep");

  // A result comes in the cycle after its lookup
  a_s1_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(lookup_en_i))
    else $error("lookup stage valid without lookup");

  // A word just marked reads back with the bit set on a repeat lookup
  a_fwd_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_inrange_q && lookup_en_i && (lookup_hash_i == s1_hash_q))
    |=> !result_o.word.first_seen)
    else $error("repeated hash reported as first seen");
`endif

endmodule

// ===== rtl/core/lhdf_ofifo.sv =====
// ----------------------------------------------------------------------------
// lhdf_ofifo
// Small result queue between the lookup stage and the output channel.
// ----------------------------------------------------------------------------
module lhdf_ofifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  lhdf_pkg::out_word_t           push_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lhdf_pkg::out_word_t           out_word_o,
  output logic [lhdf_pkg::OutCntW-1:0]  count_o
);

  localparam int Depth = lhdf_pkg::OutFifoDepth;
  localparam int PtrW  = $clog2(Depth);

  lhdf_pkg::out_word_t          entry_q [Depth];
  logic [PtrW-1:0]              wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [lhdf_pkg::OutCntW-1:0] count_q, count_d;
  logic                         pop;

  assign pop = out_valid_o && !out_stall_i;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_word_i;
    end
  end

  assign out_valid_o = count_q != '0;
  assign out_word_o  = entry_q[rd_ptr_q];
  assign count_o     = count_q;

`ifndef NO_ASSERTIONS
  // Upstream credit check keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != lhdf_pkg::OutCntW'(Depth)) || pop)
    else $error("result queue overflow");
`endif

endmodule

// ===== rtl/core/line_hash_duplicate_filter_core.sv =====
// ----------------------------------------------------------------------------
// line_hash_duplicate_filter_core
// Hashes text lines byte by byte and flags the first sighting of each line
// hash against a one-bit-per-hash seen bitmap.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | word                        | dir
//  --------+--------------+--------------+-----------------------------+-----
//  in      | in_valid_i   | in_stall_o   | in_word_i  (text_byte, eol) | in
//  out     | out_valid_o  | out_stall_i  | out_word_o (hash, first)    | out
//
// One input word per cycle while in_stall_o is low. A byte word updates the hash
// register in the cycle it is taken; an end-of-line word reads the bitmap, its
// result is registered in the lookup stage, then held in the result queue.
// After reset a clearing sweep zeroes all BITMAP_WORDS words of the bitmap
// (262144 by default), one word a cycle, with in_stall_o high.
// in_stall_o also rises when the result queue could not hold one more result.
// ----------------------------------------------------------------------------
module line_hash_duplicate_filter_core #(
  parameter int BITMAP_WORDS = lhdf_pkg::BitmapWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lhdf_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lhdf_pkg::out_word_t out_word_o
);

  localparam int PendW = lhdf_pkg::OutCntW + 1;

  logic                         in_accept;
  logic                         byte_accept;
  logic                         eol_accept;
  logic [lhdf_pkg::HashW-1:0]   hash;
  logic                         clr_busy;
  lhdf_pkg::seen_result_t       seen_res;
  logic [lhdf_pkg::OutCntW-1:0] fifo_count;
  logic [PendW-1:0]             pending;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign byte_accept = in_accept && !in_word_i.end_of_line;
  assign eol_accept  = in_accept && in_word_i.end_of_line;

  // Results queued plus the one in the lookup stage must leave a free slot
  assign pending    = PendW'(fifo_count) + PendW'(seen_res.valid);
  assign in_stall_o = clr_busy || (pending >= PendW'(lhdf_pkg::OutFifoDepth));

  lhdf_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .absorb_i(byte_accept),
    .clear_i (eol_accept),
    .byte_i  (in_word_i.text_byte),
    .hash_o  (hash)
  );

  lhdf_seen #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_seen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lookup_en_i  (eol_accept),
    .lookup_hash_i(hash),
    .busy_o       (clr_busy),
    .result_o     (seen_res)
  );

  lhdf_ofifo u_ofifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (seen_res.valid),
    .push_word_i(seen_res.word),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .count_o    (fifo_count)
  );

`ifndef NO_ASSERTIONS
  // Every line starts from hash zero
  a_hash_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eol_accept |=> (hash == '0))
    else $error("hash not restarted after line end");

  // Each line end yields a result in the lookup stage next cycle
  a_eol_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eol_accept |=> seen_res.valid)
    else $error("line end without lookup result");
`endif

endmodule

// ===== sim/lhdf_result_checker.sv =====
// ----------------------------------------------------------------------------
// lhdf_result_checker
// Watches both channels of the line hash duplicate filter. It keeps its own
// copy of the line hash and of the seen set, queues one verdict per closed
// line and compares each result word against the oldest queued verdict.
// ----------------------------------------------------------------------------
module lhdf_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  lhdf_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  lhdf_pkg::out_word_t out_word_i,
  output int                  mismatch_cnt_o,
  output int                  pending_cnt_o,
  output int                  lines_cnt_o,
  output int                  repeats_cnt_o
);

  localparam logic [31:0] LineMod  = 32'd8388593;
  localparam logic [31:0] LineMult = 32'd199;
  localparam int          ReportMax = 10;

  logic [lhdf_pkg::HashW-1:0] line_acc;      // hash of the line in progress
  bit                         hashes_seen [int unsigned];
  lhdf_pkg::out_word_t        verdicts_q [$]; // verdicts still owed by the block

  // One byte into the hash: sign-extend, multiply-add with 32-bit wrap, fold
  function automatic logic [lhdf_pkg::HashW-1:0] fold_byte(
    logic [lhdf_pkg::HashW-1:0] h,
    logic [lhdf_pkg::ByteW-1:0] b);
    logic [31:0] acc;
    acc = {{(32-lhdf_pkg::HashW){1'b0}}, h} * LineMult
        + {{(32-lhdf_pkg::ByteW){b[lhdf_pkg::ByteW-1]}}, b};
    acc = acc % LineMod;
    return acc[lhdf_pkg::HashW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lhdf_pkg::out_word_t want;
    if (!rst_ni) begin
      line_acc = '0;
      hashes_seen.delete();
      verdicts_q.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
      lines_cnt_o    = 0;
      repeats_cnt_o  = 0;
    end else begin
      // results first: a verdict queued at this edge cannot leave at it
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_q.size() == 0) begin
          if (mismatch_cnt_o < ReportMax)
            $display("%0t: result word with no line pending: hash %0d first %0b",
                     $time, out_word_i.line_hash, out_word_i.first_seen);
          mismatch_cnt_o++;
        end else begin
          want = verdicts_q.pop_front();
          if (out_word_i.line_hash !== want.line_hash ||
              out_word_i.first_seen !== want.first_seen) begin
            if (mismatch_cnt_o < ReportMax)
              $display("%0t: line %0d: expected hash %0d first %0b, got hash %0d first %0b",
                       $time, lines_cnt_o, want.line_hash, want.first_seen,
                       out_word_i.line_hash, out_word_i.first_seen);
            mismatch_cnt_o++;
          end
          lines_cnt_o++;
        end
      end

      // accepted input word: extend the hash or close the line
      if (in_valid_i && !in_stall_i) begin
        if (!in_word_i.end_of_line) begin
          line_acc = fold_byte(line_acc, in_word_i.text_byte);
        end else begin
          want.line_hash  = line_acc;
          want.first_seen = !hashes_seen.exists(line_acc);
          hashes_seen[line_acc] = 1'b1;
          if (!want.first_seen)
            repeats_cnt_o++;
          verdicts_q = {verdicts_q, want};
          line_acc = '0;
        end
      end
      pending_cnt_o = verdicts_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives text lines into the line hash duplicate filter: a short directed set
// (empty lines, sign-extended bytes, a byte riding on the end-of-line word,
// repeated lines) and then random lines, many of them replays of earlier
// ones, under random idle bursts on both channels. The checker predicts and
// compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int RandWords = 920;
  localparam int LineMax   = 40;
  localparam int BankSize  = 64;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  lhdf_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  lhdf_pkg::out_word_t out_word_o;

  int mismatch_cnt;
  int pending_cnt;
  int lines_cnt;
  int repeats_cnt;

  bit idle_on    = 1'b0;
  int stall_left = 0;
  int words_sent = 0;

  // lines kept for replay, so that duplicates come up often
  logic [lhdf_pkg::ByteW-1:0] line_bank [BankSize][LineMax];
  int                         line_len  [BankSize];
  int                         bank_fill = 0;

  always #10 clk_i = ~clk_i;

  line_hash_duplicate_filter_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  lhdf_result_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_word_i      (in_word_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_word_i     (out_word_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .lines_cnt_o    (lines_cnt),
    .repeats_cnt_o  (repeats_cnt)
  );

  // Random receiver stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // One word onto the input channel, with an optional idle burst in front
  task automatic send_word(input logic [lhdf_pkg::ByteW-1:0] b, input logic eol);
    lhdf_pkg::in_word_t w;
    w.text_byte   = b;
    w.end_of_line = eol;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Directed line: len bytes, right-aligned in txt, first byte highest
  task automatic send_line(input logic [63:0] txt, input int len,
                           input logic [lhdf_pkg::ByteW-1:0] eol_byte);
    for (int i = 0; i < len; i++)
      send_word(txt[8*(len-1-i) +: 8], 1'b0);
    send_word(eol_byte, 1'b1);
  endtask

  initial begin
    int  base;
    int  phase;
    int  pick;
    int  len;
    int  r;
    bit  paused;
    paused = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed lines
    send_line(64'h0, 0, 8'hA5);           // empty line, byte on the end word dropped
    send_line(64'h0, 0, 8'h00);           // empty again: hash zero repeats
    send_line(64'h00, 1, 8'hFF);          // zero byte keeps hash zero
    send_line(64'hFF, 1, 8'h3C);          // all-ones byte, sign-extended
    send_line(64'hFF, 1, 8'h80);          // same line again
    send_line(64'h807F, 2, 8'h7F);        // sign boundary both ways
    send_line(64'h7F80, 2, 8'h01);
    send_line(64'h01FE55AA, 4, 8'hFE);
    send_line(64'h01FE55AA, 4, 8'h55);    // exact repeat

    // random lines, some of them replays
    base = words_sent;
    while (words_sent - base < RandWords) begin
      phase = words_sent - base;
      idle_on <= (phase < 350 || phase >= 450) && phase < 800;

      // let the block drain completely once
      if (!paused && phase >= 600) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending_cnt != 0);
      end

      if (bank_fill > 0 && $urandom_range(0, 9) < 3) begin
        pick = $urandom_range(0, bank_fill - 1);
      end else begin
        if (bank_fill < BankSize) begin
          pick = bank_fill;
          bank_fill++;
        end else begin
          pick = $urandom_range(0, BankSize - 1);
        end
        r = $urandom_range(0, 19);
        if (r < 1)
          len = 0;
        else if (r < 14)
          len = $urandom_range(1, 6);
        else if (r < 19)
          len = $urandom_range(7, 20);
        else
          len = $urandom_range(21, LineMax);
        line_len[pick] = len;
        for (int i = 0; i < len; i++)
          line_bank[pick][i] = ($urandom_range(0, 3) == 0) ?
                               lhdf_pkg::ByteW'($urandom_range(32, 126)) :
                               lhdf_pkg::ByteW'($urandom_range(0, 255));
      end

      for (int i = 0; i < line_len[pick]; i++)
        send_word(line_bank[pick][i], 1'b0);
      send_word(lhdf_pkg::ByteW'($urandom_range(0, 255)), 1'b1);
    end
    in_valid_i <= 1'b0;

    // drain, then a few quiet cycles for any stray word
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    $display("run covered %0d input words and %0d closed lines, %0d of them repeats",
             words_sent, lines_cnt, repeats_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Timeout: bitmap clearing after reset plus a wide margin for the traffic
  initial begin
    #30000000;
    $display("tb: errors");
    $finish;
  end

endmodule
